// ===== rtl/mpm_pkg.sv =====
// shared types and constants for the 2x2 matrix power mod prime block
`timescale 1ns / 1ps
`default_nettype none

package mpm_pkg;

    // prime modulus and barrett constants
    localparam logic [29:0] MOD_PRIME    = 30'd998244353;
    localparam logic [31:0] TWO_PRIME    = 32'd1996488706;
    localparam logic [63:0] BARRETT_MU_W = (64'd1 << 61) / 64'd998244353;
    localparam logic [31:0] BARRETT_MU   = BARRETT_MU_W[31:0];

    // shared unit step codes
    localparam logic [1:0] STEP_MUL_LO = 2'd0;
    localparam logic [1:0] STEP_MUL_HI = 2'd1;
    localparam logic [1:0] STEP_QUOT   = 2'd2;
    localparam logic [1:0] STEP_REM    = 2'd3;

    // entry order: 00, 01, 10, 11
    typedef logic [3:0][29:0] mat_t;

    typedef struct packed {
        logic [29:0] m00;
        logic [29:0] m01;
        logic [29:0] m10;
        logic [29:0] m11;
        logic [62:0] power;
    } in_t;

    typedef struct packed {
        logic [29:0] r00;
        logic [29:0] r01;
        logic [29:0] r10;
        logic [29:0] r11;
    } out_t;

    typedef struct packed {
        logic       en;
        logic [1:0] step;
    } mpm_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/mpm_mul_unit.sv =====
// shared multiplier with dot-product accumulate and barrett reduction
`timescale 1ns / 1ps
`default_nettype none

module mpm_mul_unit (
    input  wire logic             clk,
    input  wire mpm_pkg::mpm_ctl_t ctl,
    input  wire logic [29:0]      opa,
    input  wire logic [29:0]      opb,
    output logic      [29:0]      res
);

    logic [60:0] sum_reg;
    logic [31:0] q_reg;
    logic [31:0] rem_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [31:0] fixed;

    // operand select for the one multiplier
    always_comb
    begin
        case (ctl.step)
            mpm_pkg::STEP_MUL_LO, mpm_pkg::STEP_MUL_HI:
            begin
                mul_a = {2'b00, opa};
                mul_b = {2'b00, opb};
            end
            mpm_pkg::STEP_QUOT:
            begin
                mul_a = sum_reg[60:29];
                mul_b = mpm_pkg::BARRETT_MU;
            end
            default:
            begin
                mul_a = q_reg;
                mul_b = {2'b00, mpm_pkg::MOD_PRIME};
            end
        endcase
    end

    assign prod = {32'd0, mul_a} * {32'd0, mul_b};

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            case (ctl.step)
                mpm_pkg::STEP_MUL_LO: sum_reg <= prod[60:0];
                mpm_pkg::STEP_MUL_HI: sum_reg <= sum_reg + prod[60:0];
                mpm_pkg::STEP_QUOT:   q_reg   <= prod[63:32];
                default:              rem_reg <= sum_reg[31:0] - prod[31:0];
            endcase
        end
    end

    // quotient estimate is short by at most two
    always_comb
    begin
        if (rem_reg >= mpm_pkg::TWO_PRIME)
            fixed = rem_reg - mpm_pkg::TWO_PRIME;
        else if (rem_reg >= {2'b00, mpm_pkg::MOD_PRIME})
            fixed = rem_reg - {2'b00, mpm_pkg::MOD_PRIME};
        else
            fixed = rem_reg;
    end

    assign res = fixed[29:0];

endmodule

`default_nettype wire

// ===== rtl/matrix_power_mod_prime_top.sv =====
// top level: 2x2 matrix power modulo 998244353 by square-and-multiply
`timescale 1ns / 1ps
`default_nettype none

// usage
//   a transaction is taken when start is high and busy is low; item carries the
//   four matrix entries and a 63-bit exponent. entries at or above the prime
//   are reduced on entry.
//   when the power is ready, result holds the four entries for exactly one
//   cycle with done high. the receiver cannot stall; a new start may be given
//   in the same cycle that done is high.
// sequence
//   each 2x2 product runs four entries, each with four passes through
//   the single shared 32x32 multiplier (two products, barrett quotient,
//   quotient times prime), then a commit step that writes the new matrix.
//   per exponent bit up to the top set bit: a decide step, a squaring,
//   and one more product when the bit is set; the squaring after the top bit
//   is skipped. a zero exponent goes from decide straight to done.
// throughput
//   one transaction at a time; busy stays high until done.
// reset
//   rst_n clears the sequencer and the done strobe; the block comes up idle.

module matrix_power_mod_prime_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire mpm_pkg::in_t  item,
    output logic               done,
    output mpm_pkg::out_t      result
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_PROD   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         ent_reg;
    logic [1:0]         step_reg;
    logic               sq_reg;
    logic               done_reg;
    logic [62:0]        exp_reg;
    mpm_pkg::mat_t      acc_reg;
    mpm_pkg::mat_t      base_reg;
    logic [2:0][29:0]   new_reg;
    mpm_pkg::out_t      result_reg;

    logic               accept;
    logic               last_bit;
    mpm_pkg::mat_t      src_x;
    mpm_pkg::mat_t      prod_mat;
    logic [29:0]        opa;
    logic [29:0]        opb;
    logic [29:0]        unit_res;
    mpm_pkg::mpm_ctl_t  ctl;

    function automatic logic [29:0] reduce_entry(input logic [29:0] m);
        if (m >= mpm_pkg::MOD_PRIME)
            return m - mpm_pkg::MOD_PRIME;
        else
            return m;
    endfunction

    assign accept   = start && (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign result   = result_reg;
    assign last_bit = (exp_reg[62:1] == 62'd0);

    // operands: x[i][k] * base[k][j], k follows the low step bit
    assign src_x = sq_reg ? base_reg : acc_reg;
    assign opa   = src_x[{ent_reg[1], step_reg[0]}];
    assign opb   = base_reg[{step_reg[0], ent_reg[0]}];

    assign ctl.en   = (state_reg == S_PROD);
    assign ctl.step = step_reg;

    // newest entry comes straight from the unit at commit
    assign prod_mat = {unit_res, new_reg[2], new_reg[1], new_reg[0]};

    mpm_mul_unit u_mul (
        .clk (clk),
        .ctl (ctl),
        .opa (opa),
        .opb (opb),
        .res (unit_res)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ent_reg   <= 2'd0;
            step_reg  <= mpm_pkg::STEP_MUL_LO;
            sq_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (exp_reg == 63'd0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        // set bit: multiply into acc first, then square
                        sq_reg    <= ~exp_reg[0];
                        state_reg <= S_PROD;
                    end
                end
                S_PROD:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == mpm_pkg::STEP_REM)
                    begin
                        ent_reg <= ent_reg + 2'd1;
                        if (ent_reg == 2'd3)
                            state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT:
                begin
                    if (!sq_reg && !last_bit)
                    begin
                        sq_reg    <= 1'b1;
                        state_reg <= S_PROD;
                    end
                    else
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // matrices and exponent
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    base_reg[0] <= reduce_entry(item.m00);
                    base_reg[1] <= reduce_entry(item.m01);
                    base_reg[2] <= reduce_entry(item.m10);
                    base_reg[3] <= reduce_entry(item.m11);
                    acc_reg     <= {30'd1, 30'd0, 30'd0, 30'd1};
                    exp_reg     <= item.power;
                end
            end
            S_DECIDE:
            begin
                if (exp_reg == 63'd0)
                begin
                    result_reg.r00 <= acc_reg[0];
                    result_reg.r01 <= acc_reg[1];
                    result_reg.r10 <= acc_reg[2];
                    result_reg.r11 <= acc_reg[3];
                end
            end
            S_PROD:
            begin
                // previous entry's residue is ready at the first step
                if ((step_reg == mpm_pkg::STEP_MUL_LO) && (ent_reg != 2'd0))
                    new_reg[ent_reg - 2'd1] <= unit_res;
            end
            S_COMMIT:
            begin
                if (!sq_reg)
                begin
                    acc_reg <= prod_mat;
                    // no squaring needed after the top bit
                    if (last_bit)
                        exp_reg <= 63'd0;
                end
                else
                begin
                    base_reg <= prod_mat;
                    exp_reg  <= exp_reg >> 1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // a taken transaction always leaves the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("block not busy after a transaction was taken");

    // done only follows a decide with the exponent used up
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_DECIDE && exp_reg == 63'd0))
        else $error("done without a finished exponent scan");

    // every delivered entry is a proper residue
    a_done_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.r00 < mpm_pkg::MOD_PRIME) && (result.r01 < mpm_pkg::MOD_PRIME)
              && (result.r10 < mpm_pkg::MOD_PRIME) && (result.r11 < mpm_pkg::MOD_PRIME))
        else $error("result entry not reduced");

    // entry and step counters rest at zero outside a product
    a_counters_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_PROD) |-> (step_reg == mpm_pkg::STEP_MUL_LO) && (ent_reg == 2'd0))
        else $error("product counters out of step");

    // done is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

endmodule

`default_nettype wire
